// File: rtl/core/ray_sphere_closest_hit_top_macros.svh
// assertion helpers for the ray sphere closest hit block
`ifndef RAY_SPHERE_CLOSEST_HIT_TOP_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RSCH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define RSCH_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define RSCH_ASSERT(lbl, prop, msg)
`define RSCH_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/rsch_pkg.sv
package rsch_pkg;

   localparam int COORD_BITS      = 16;
   localparam int SLOT_W          = 4;
   localparam int CNT_CFG_W       = 5;
   localparam int RAD_W           = 15;
   localparam int OC_W            = COORD_BITS + 1;
   localparam int PROD_W          = OC_W + COORD_BITS;
   localparam int HB_W            = PROD_W + 2;
   localparam int K_W             = PROD_W + 1;
   localparam int A_W             = 2 * COORD_BITS;
   localparam int R2_W            = 2 * RAD_W;
   localparam int MAG_W           = 31;
   localparam int SQ_W            = 2 * MAG_W;
   localparam int CROSS_W         = SQ_W + 2;
   localparam int AR2_W           = A_W + R2_W;
   localparam int DISC_W          = AR2_W;
   localparam int ROOT_W          = DISC_W / 2;
   localparam int NUM_W           = HB_W + 1;
   localparam int FRAC_BITS       = 16;
   localparam int DVD_W           = HB_W + FRAC_BITS;
   localparam int DIST_W          = 32;
   localparam int REQ_DATA_W      = 120;
   localparam int RSP_DATA_W      = 40;
   localparam int QUEUE_DEPTH     = 2;
   localparam int MAX_SPHERES_DEF = 16;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_CAST  = 1'b1
   } rsch_cmd_type;

   typedef struct packed {
      rsch_cmd_type                  cmd;
      logic [SLOT_W-1:0]             slot;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
      logic signed [COORD_BITS-1:0]  dir_x;
      logic signed [COORD_BITS-1:0]  dir_y;
      logic signed [COORD_BITS-1:0]  dir_z;
      logic [RAD_W-1:0]              radius;
   } rsch_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  cx;
      logic signed [COORD_BITS-1:0]  cy;
      logic signed [COORD_BITS-1:0]  cz;
      logic [RAD_W-1:0]              rad;
   } rsch_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_OC,
      ST_MUL,
      ST_SUM,
      ST_SQ,
      ST_CMP,
      ST_SQRT,
      ST_DIV,
      ST_NEXT,
      ST_OUT
   } rsch_state_type;

endpackage

// File: rtl/core/rsch_front.sv
module rsch_front #(
   parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sphere_radius, zero pad
   input  logic [rsch_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                            req_tuser,
   output logic                            q_valid,
   input  logic                            q_ready,
   output rsch_pkg::rsch_item_type         q_item
);
   import rsch_pkg::*;

   rsch_item_type item_in;
   rsch_item_type hold_ff;
   logic          hold_valid_ff;
   logic          hold_valid_in;
   logic          keep;
   logic          accept;

   always_comb begin
      item_in.cmd    = rsch_cmd_type'(req_tuser);
      item_in.slot   = req_tdata[3:0];
      item_in.pos_x  = req_tdata[19:4];
      item_in.pos_y  = req_tdata[35:20];
      item_in.pos_z  = req_tdata[51:36];
      item_in.dir_x  = req_tdata[67:52];
      item_in.dir_y  = req_tdata[83:68];
      item_in.dir_z  = req_tdata[99:84];
      item_in.radius = req_tdata[114:100];
   end

   // writes beyond the table are dropped here
   assign keep       = (item_in.cmd == CMD_CAST) || (int'(item_in.slot) < MAX_SPHERES);
   assign req_tready = !hold_valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff && !q_ready;
      if (accept && keep) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= item_in;
      end
   end

   assign q_valid = hold_valid_ff;
   assign q_item  = hold_ff;

endmodule

// File: rtl/core/rsch_queue.sv
`include "ray_sphere_closest_hit_top_macros.svh"
module rsch_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rsch_pkg::rsch_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsch_pkg::rsch_item_type out_item
);
   import rsch_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   rsch_item_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              push;
   logic              pop;

   assign in_ready  = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   `RSCH_ASSERT(a_queue_fill_bound, fill_ff <= FILL_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

// File: rtl/core/rsch_isqrt.sv
module rsch_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsch_pkg::DISC_W-1:0]   radicand,
   output logic                          done,
   output logic [rsch_pkg::ROOT_W-1:0]   root
);
   import rsch_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W);
   localparam int REM_W  = ROOT_W + 2;

   logic [DISC_W-1:0] rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              take;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[DISC_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= STEP_W'(ROOT_W - 1);
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[DISC_W-3:0], 2'b00};
         rem_ff  <= take ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], take};
         step_ff <= step_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/core/rsch_div.sv
module rsch_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rsch_pkg::DVD_W-1:0]  dividend,
   input  logic [rsch_pkg::A_W-1:0]    divisor,
   output logic                        done,
   output logic [rsch_pkg::DVD_W-1:0]  quotient
);
   import rsch_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);

   logic [DVD_W-1:0]  quo_ff;
   logic [A_W-1:0]    rem_ff;
   logic [A_W-1:0]    dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [A_W:0]      rem_sh;
   logic              take;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign take   = (rem_sh >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         step_ff <= STEP_W'(DVD_W - 1);
      end else if (busy_ff) begin
         rem_ff  <= take ? A_W'(rem_sh - {1'b0, dvs_ff}) : A_W'(rem_sh);
         quo_ff  <= {quo_ff[DVD_W-2:0], take};
         step_ff <= step_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/rsch_back.sv
`include "ray_sphere_closest_hit_top_macros.svh"
module rsch_back #(
   parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  rsch_pkg::rsch_item_type         item,
   input  logic [rsch_pkg::CNT_CFG_W-1:0]  sphere_count,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit_slot, distance, zero pad
   output logic [rsch_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                            rsp_tuser
);
   import rsch_pkg::*;

   localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int CNT_W = $clog2(MAX_SPHERES + 1);

   rsch_state_type state_ff, state_in;

   rsch_entry_type table_mem [MAX_SPHERES];
   rsch_entry_type rd_ff;
   rsch_item_type  ray_ff;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] n_ff;
   logic [CNT_W-1:0] n_in;

   logic signed [OC_W-1:0]   ocx_ff, ocy_ff, ocz_ff;
   logic [RAD_W-1:0]         r_ff;
   logic signed [PROD_W-1:0] hx_ff, hy_ff, hz_ff;
   logic signed [PROD_W-1:0] yz_ff, zy_ff, zx_ff, xz_ff, xy_ff, yx_ff;
   logic signed [PROD_W-1:0] hx_in, hy_in, hz_in;
   logic signed [PROD_W-1:0] yz_in, zy_in, zx_in, xz_in, xy_in, yx_in;
   logic signed [A_W-1:0]    ax_in, ay_in, az_in;
   logic [A_W-1:0]           a_ff;
   logic [R2_W-1:0]          r2_ff;
   logic [R2_W-1:0]          r2_in;
   logic signed [HB_W-1:0]   hb_ff;
   logic signed [K_W-1:0]    k0_ff, k1_ff, k2_ff;
   logic [AR2_W-1:0]         ar2_ff;
   logic [AR2_W-1:0]         ar2_in;
   logic [K_W-1:0]           m0, m1, m2;
   logic                     big_ff;
   logic [SQ_W-1:0]          sq0_ff, sq1_ff, sq2_ff;
   logic [SQ_W-1:0]          sq0_in, sq1_in, sq2_in;
   logic [CROSS_W-1:0]       cross2;
   logic                     miss_early;
   logic signed [NUM_W-1:0]  num;
   logic                     num_pos;

   logic                     found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [DVD_W-1:0]         best_t_ff;
   logic                     better;

   logic                     sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]        root;
   logic                     div_start, div_done;
   logic [DVD_W-1:0]         quo;

   logic                     take_item;
   logic                     load_out;
   logic                     out_free;
   logic                     rsp_valid_ff;
   logic                     hit_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [DIST_W-1:0]        dist_ff;

   assign n_in = (int'(sphere_count) > MAX_SPHERES) ? CNT_W'(MAX_SPHERES)
                                                    : CNT_W'(sphere_count);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // per sphere datapath terms
   always_comb begin
      hx_in = ocx_ff * ray_ff.dir_x;
      hy_in = ocy_ff * ray_ff.dir_y;
      hz_in = ocz_ff * ray_ff.dir_z;
      yz_in = ocy_ff * ray_ff.dir_z;
      zy_in = ocz_ff * ray_ff.dir_y;
      zx_in = ocz_ff * ray_ff.dir_x;
      xz_in = ocx_ff * ray_ff.dir_z;
      xy_in = ocx_ff * ray_ff.dir_y;
      yx_in = ocy_ff * ray_ff.dir_x;
      ax_in = ray_ff.dir_x * ray_ff.dir_x;
      ay_in = ray_ff.dir_y * ray_ff.dir_y;
      az_in = ray_ff.dir_z * ray_ff.dir_z;
      r2_in = r_ff * r_ff;
      ar2_in = a_ff * r2_ff;
      m0 = k0_ff[K_W-1] ? K_W'(-k0_ff) : K_W'(k0_ff);
      m1 = k1_ff[K_W-1] ? K_W'(-k1_ff) : K_W'(k1_ff);
      m2 = k2_ff[K_W-1] ? K_W'(-k2_ff) : K_W'(k2_ff);
      sq0_in = m0[MAG_W-1:0] * m0[MAG_W-1:0];
      sq1_in = m1[MAG_W-1:0] * m1[MAG_W-1:0];
      sq2_in = m2[MAG_W-1:0] * m2[MAG_W-1:0];
      cross2 = CROSS_W'(sq0_ff) + CROSS_W'(sq1_ff) + CROSS_W'(sq2_ff);
      miss_early = big_ff || (cross2 >= CROSS_W'(ar2_ff)) || (a_ff == '0);
      num = -NUM_W'(hb_ff) - $signed(NUM_W'(root));
      num_pos = !num[NUM_W-1] && (num != '0);
      better = (quo != '0) && (!found_ff || (quo < best_t_ff));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && (item.cmd == CMD_CAST)) begin
               state_in = (n_in == '0) ? ST_OUT : ST_READ;
            end
         end
         ST_READ: state_in = ST_OC;
         ST_OC:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_CMP;
         ST_CMP:  state_in = miss_early ? ST_NEXT : ST_SQRT;
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = num_pos ? ST_DIV : ST_NEXT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: state_in = ((cnt_ff + 1'b1) == n_ff) ? ST_OUT : ST_READ;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      item_ready = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ST_IDLE: item_ready = 1'b1;
         ST_CMP:  sqrt_start = !miss_early;
         ST_SQRT: div_start  = sqrt_done && num_pos;
         ST_OUT:  load_out   = out_free;
         default: item_ready = 1'b0;
      endcase
   end

   assign take_item = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_item && (item.cmd == CMD_WRITE)) begin
         table_mem[IDX_W'(item.slot)] <= '{cx: item.pos_x, cy: item.pos_y,
                                          cz: item.pos_z, rad: item.radius};
      end
      if (state_ff == ST_READ) begin
         rd_ff <= table_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (take_item && (item.cmd == CMD_CAST)) begin
         ray_ff   <= item;
         n_ff     <= n_in;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (state_ff == ST_OC) begin
         ocx_ff <= OC_W'(ray_ff.pos_x) - OC_W'(rd_ff.cx);
         ocy_ff <= OC_W'(ray_ff.pos_y) - OC_W'(rd_ff.cy);
         ocz_ff <= OC_W'(ray_ff.pos_z) - OC_W'(rd_ff.cz);
         r_ff   <= rd_ff.rad;
      end
      if (state_ff == ST_MUL) begin
         hx_ff <= hx_in;
         hy_ff <= hy_in;
         hz_ff <= hz_in;
         yz_ff <= yz_in;
         zy_ff <= zy_in;
         zx_ff <= zx_in;
         xz_ff <= xz_in;
         xy_ff <= xy_in;
         yx_ff <= yx_in;
         a_ff  <= unsigned'(ax_in) + unsigned'(ay_in) + unsigned'(az_in);
         r2_ff <= r2_in;
      end
      if (state_ff == ST_SUM) begin
         hb_ff  <= HB_W'(hx_ff) + HB_W'(hy_ff) + HB_W'(hz_ff);
         k0_ff  <= K_W'(yz_ff) - K_W'(zy_ff);
         k1_ff  <= K_W'(zx_ff) - K_W'(xz_ff);
         k2_ff  <= K_W'(xy_ff) - K_W'(yx_ff);
         ar2_ff <= ar2_in;
      end
      if (state_ff == ST_SQ) begin
         big_ff <= (|m0[K_W-1:MAG_W]) || (|m1[K_W-1:MAG_W]) || (|m2[K_W-1:MAG_W]);
         sq0_ff <= sq0_in;
         sq1_ff <= sq1_in;
         sq2_ff <= sq2_in;
      end
      if ((state_ff == ST_DIV) && div_done && better) begin
         found_ff    <= 1'b1;
         best_idx_ff <= cnt_ff[IDX_W-1:0];
         best_t_ff   <= quo;
      end
      if (state_ff == ST_NEXT) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (load_out) begin
         hit_ff  <= found_ff;
         slot_ff <= found_ff ? SLOT_W'(best_idx_ff) : '0;
         if (!found_ff) begin
            dist_ff <= '0;
         end else if (|best_t_ff[DVD_W-1:DIST_W]) begin
            dist_ff <= '1;
         end else begin
            dist_ff <= best_t_ff[DIST_W-1:0];
         end
      end
   end

   rsch_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (DISC_W'(ar2_ff - cross2[AR2_W-1:0])),
      .done     (sqrt_done),
      .root     (root)
   );

   rsch_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({num[HB_W-1:0], FRAC_BITS'(0)}),
      .divisor  (a_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - DIST_W)'(0), dist_ff, slot_ff};
   assign rsp_tuser  = hit_ff;

   `RSCH_ASSERT_IMPL(a_out_no_overwrite, load_out, !rsp_valid_ff || rsp_tready,
                     "result overwritten before taken")
   `RSCH_ASSERT_IMPL(a_div_nonzero, div_start, a_ff != '0, "divide by zero started")
   `RSCH_ASSERT_IMPL(a_read_in_range, state_ff == ST_READ, cnt_ff < n_ff,
                     "sphere index past count")

endmodule

// File: rtl/core/ray_sphere_closest_hit_top.sv
// write request: updates the sphere table, no response
// cast request: per tested sphere read, offset, multiply, sum, square, compare; a root
//   if the discriminant is positive, a divide if the numerator is too, all in the back end
// one request in the back end at a time; a two entry queue and the output register decouple
// reset clears sphere_count, queue and control; the sphere table is undefined until written
module ray_sphere_closest_hit_top #(
   parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // slot, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sphere_radius, zero pad
   input  logic [rsch_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit_slot, distance, zero pad
   output logic [rsch_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rsch_pkg::CNT_CFG_W-1:0]  csr_data
);
   import rsch_pkg::*;

   logic [CNT_CFG_W-1:0] count_ff;
   logic                 f_valid, f_ready;
   rsch_item_type        f_item;
   logic                 b_valid, b_ready;
   rsch_item_type        b_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   rsch_front #(.MAX_SPHERES(MAX_SPHERES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (f_valid),
      .q_ready    (f_ready),
      .q_item     (f_item)
   );

   rsch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_item  (b_item)
   );

   rsch_back #(.MAX_SPHERES(MAX_SPHERES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (b_valid),
      .item_ready   (b_ready),
      .item         (b_item),
      .sphere_count (count_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rsch_pkg::*;

   localparam int NSPH       = 16;
   localparam int STALL_MAX  = 60000;
   localparam int SETTLE     = 40;

   typedef struct {
      logic        hit;
      logic [3:0]  slot;
      logic [31:0] distance;
   } hit_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CNT_CFG_W-1:0]   csr_data;

   rsch_entry_type   sphere_mem [NSPH];
   logic [4:0]       active_count;
   hit_result_type   hit_expect_q [$];
   int               errors;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               hold_cycles;
   int               quiet_cycles;

   ray_sphere_closest_hit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] acc;
      logic [63:0] cand;
      acc = 64'd0;
      for (int b = 31; b >= 0; b--) begin
         cand = acc | (64'd1 << b);
         if (cand * cand <= v) acc = cand;
      end
      return acc[31:0];
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // nearest positive intersection of one sphere; returns 0 on a miss
   function automatic bit sphere_hit(rsch_entry_type s, longint o[3], longint d[3],
                                     output logic [63:0] t);
      longint      ox, oy, oz, a, hb, k0, k1, k2, num;
      logic [63:0] m0, m1, m2, cross2, ar2, disc, rr;
      t = 64'd0;
      ox = o[0] - longint'(s.cx);
      oy = o[1] - longint'(s.cy);
      oz = o[2] - longint'(s.cz);
      a  = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      hb = ox * d[0] + oy * d[1] + oz * d[2];
      k0 = oy * d[2] - oz * d[1];
      k1 = oz * d[0] - ox * d[2];
      k2 = ox * d[1] - oy * d[0];
      m0 = magnitude(k0);
      m1 = magnitude(k1);
      m2 = magnitude(k2);
      if (m0 >= 64'h8000_0000 || m1 >= 64'h8000_0000 || m2 >= 64'h8000_0000) return 0;
      rr     = 64'(s.rad) * 64'(s.rad);
      ar2    = 64'(a) * rr;
      cross2 = m0 * m0 + m1 * m1 + m2 * m2;
      if (cross2 >= ar2 || a == 0) return 0;
      disc = ar2 - cross2;
      num  = -hb - longint'({32'd0, floor_root(disc)});
      if (num <= 0) return 0;
      t = (64'(num) << 16) / 64'(a);
      return t != 64'd0;
   endfunction

   function automatic hit_result_type closest_hit(rsch_item_type it);
      hit_result_type r;
      longint         o[3], d[3];
      logic [63:0]    t, best_t;
      int             n;
      o[0] = longint'(it.pos_x); o[1] = longint'(it.pos_y); o[2] = longint'(it.pos_z);
      d[0] = longint'(it.dir_x); d[1] = longint'(it.dir_y); d[2] = longint'(it.dir_z);
      r.hit = 1'b0; r.slot = 4'd0; r.distance = 32'd0;
      best_t = 64'd0;
      n = (active_count > NSPH) ? NSPH : active_count;
      for (int i = 0; i < n; i++) begin
         if (sphere_hit(sphere_mem[i], o, d, t) && (!r.hit || t < best_t)) begin
            r.hit  = 1'b1;
            r.slot = 4'(i);
            best_t = t;
         end
      end
      if (r.hit) r.distance = (best_t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best_t[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      hit_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_expect_q.size() == 0) begin
            report_mismatch("unexpected response", {31'd0, rsp_tuser}, 32'd0);
         end else begin
            exp_r = hit_expect_q.pop_front();
            if (rsp_tuser !== exp_r.hit)
               report_mismatch("hit", {31'd0, rsp_tuser}, {31'd0, exp_r.hit});
            if (rsp_tdata[3:0] !== exp_r.slot)
               report_mismatch("hit_slot", {28'd0, rsp_tdata[3:0]}, {28'd0, exp_r.slot});
            if (rsp_tdata[35:4] !== exp_r.distance)
               report_mismatch("distance", rsp_tdata[35:4], exp_r.distance);
            if (rsp_tdata[39:36] !== 4'd0) report_mismatch("pad", {28'd0, rsp_tdata[39:36]}, 32'd0);
         end
      end
   end

   // result side flow control
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("ray_sphere_closest_hit_top verification failed");
         $finish;
      end
   end

   task automatic send_request(rsch_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {5'd0, it.radius, it.dir_z, it.dir_y, it.dir_x,
                     it.pos_z, it.pos_y, it.pos_x, it.slot};
      do @(posedge clock); while (!req_tready);
      if (it.cmd == CMD_WRITE) begin
         sphere_mem[it.slot] = '{cx: it.pos_x, cy: it.pos_y, cz: it.pos_z, rad: it.radius};
      end else begin
         hit_expect_q.push_back(closest_hit(it));
      end
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hit_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_count(logic [4:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_count = v;
   endtask

   function automatic rsch_item_type write_item(int s, int x, int y, int z, int r);
      rsch_item_type it;
      it = '0;
      it.cmd = CMD_WRITE; it.slot = 4'(s);
      it.pos_x = 16'(x); it.pos_y = 16'(y); it.pos_z = 16'(z); it.radius = 15'(r);
      return it;
   endfunction

   function automatic rsch_item_type cast_item(int x, int y, int z, int dx, int dy, int dz);
      rsch_item_type it;
      it = '0;
      it.cmd = CMD_CAST; it.slot = 4'($urandom_range(15));
      it.pos_x = 16'(x); it.pos_y = 16'(y); it.pos_z = 16'(z);
      it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
      it.radius = 15'($urandom);
      return it;
   endfunction

   function automatic int near_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   // random sphere write, ray aimed at a stored sphere, or plain noise with random content
   function automatic rsch_item_type random_request();
      rsch_item_type  it;
      rsch_entry_type e;
      int             ox, oy, oz, sh;
      int unsigned    pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         it = write_item($urandom_range(15), near_coord(6000), near_coord(6000),
                         near_coord(6000), $urandom_range(128, 2000));
      end else if (pick < 30) begin
         it = rsch_item_type'($bits(rsch_item_type)'({$urandom, $urandom, $urandom,
                                                       $urandom}));
      end else begin
         e  = sphere_mem[$urandom_range(NSPH - 1)];
         ox = near_coord(3000); oy = near_coord(3000); oz = near_coord(3000);
         sh = $urandom_range(0, 5);
         it = cast_item(ox, oy, oz, (int'(e.cx) - ox) >>> sh, (int'(e.cy) - oy) >>> sh,
                        (int'(e.cz) - oz) >>> sh);
         if ($urandom_range(9) == 0) it.dir_x = 16'(near_coord(300));
      end
      return it;
   endfunction

   task automatic test_directed;
      for (int i = 0; i < NSPH; i++) send_request(write_item(i, i * 512 - 4096, 256, 2560, 300));
      set_count(5'd0);
      send_request(cast_item(0, 0, 0, 0, 0, 256));
      set_count(5'd16);
      send_request(cast_item(0, 256, 0, 0, 0, 256));
      send_request(cast_item(0, 0, 0, 0, 0, 0));
      send_request(cast_item(-4096, 256, 0, 0, 0, 1));
      send_request(cast_item(-4096, 256, 5000, 0, 0, 256));
      send_request(cast_item(-4096, 256, 2560, 0, 0, 256));
      // identical spheres, the lower slot wins
      send_request(write_item(4, 0, 0, 1024, 256));
      send_request(write_item(5, 0, 0, 1024, 256));
      send_request(cast_item(0, 0, 0, 0, 0, 256));
      send_request(write_item(6, -32768, -32768, -32768, 32767));
      send_request(write_item(7, 32767, 32767, 32767, 0));
      set_count(5'd31);
      send_request(cast_item(32767, 32767, 32767, -32768, -32768, -32768));
      send_request(cast_item(-32768, -32768, -32768, 32767, 32767, 32767));
      send_request(cast_item(0, 0, 0, -32768, -32768, -32768));
      set_count(5'd1);
      send_request(cast_item(-4096, 256, 0, 0, 0, 32767));
      send_request(cast_item(-4096, 256, 0, 1, 0, 1));
   endtask

   task automatic test_random(int snd, int rcv, int n);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (int k = 0; k < 4; k++) begin
         set_count((k == 0) ? 5'd16 : 5'($urandom_range(1, 16)));
         for (int j = 0; j < n / 4; j++) send_request(random_request());
      end
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_count(5'd4);
      hold_cycles <= 3000;
      for (int j = 0; j < 12; j++) send_request(cast_item(near_coord(500), near_coord(500),
                                                        -2000, 0, 0, 256));
   endtask

   initial begin
      errors        = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 0;
      quiet_cycles  = 0;
      active_count  = 5'd0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(38, 46, 560);
      test_backpressure();
      test_random(46, 38, 560);
      test_random(0, 0, 560);
      drain();
      if (errors == 0) begin
         $display("ray_sphere_closest_hit_top verification clean");
      end else begin
         $display("ray_sphere_closest_hit_top verification failed");
      end
      $finish;
   end

endmodule
